[hw/rtl/utdt_pkg.sv]
// Shared types, constants and helper functions for the epoch-to-date text unit.
// No dependencies; imported by every RTL file of the block.
package utdt_pkg;

    localparam int EPOCH_W  = 38;
    localparam int CHAR_W   = 7;
    localparam int POS_W    = 5;
    localparam int TEXT_LEN = 19;
    localparam int REM_W    = EPOCH_W;
    localparam int QUO_W    = 22;   // widest quotient: days since epoch
    localparam int CNT_W    = 5;
    localparam int YEAR_W   = 14;

    localparam logic [EPOCH_W-1:0] MAX_EPOCH = 38'd253402300799;  // 9999-12-31 23:59:59

    // divisors used by the shared subtract unit
    localparam int DAY_SEC     = 86400;
    localparam int ERA_DAYS    = 146097;   // 400 years
    localparam int CENT_DAYS   = 36524;    // 100 years, no leap century
    localparam int QUAD_DAYS   = 1461;     // 4 years
    localparam int YEAR_DAYS   = 365;
    localparam int CENT_YEARS  = 100;
    localparam int HOUR_SEC    = 3600;
    localparam int MIN_SEC     = 60;

    // day count is rebased to 1601-01-01, the start of a 400-year cycle
    localparam int BASE_YEAR   = 1601;
    localparam int BASE_OFFSET = 134774;   // days 1601-01-01 .. 1970-01-01

    // top quotient bit index for each division pass
    localparam logic [CNT_W-1:0] CNT_DAYS  = 5'd21;
    localparam logic [CNT_W-1:0] CNT_ERA   = 5'd4;
    localparam logic [CNT_W-1:0] CNT_CENT  = 5'd1;
    localparam logic [CNT_W-1:0] CNT_QUAD  = 5'd4;
    localparam logic [CNT_W-1:0] CNT_YEAR  = 5'd1;
    localparam logic [CNT_W-1:0] CNT_YSPL  = 5'd6;
    localparam logic [CNT_W-1:0] CNT_HOUR  = 5'd4;
    localparam logic [CNT_W-1:0] CNT_MIN   = 5'd5;

    localparam logic [1:0] Q1_LAST   = 2'd3;    // last year of a 4-year block
    localparam logic [1:0] Q100_LAST = 2'd3;    // last century of an era
    localparam logic [4:0] Q4_LAST   = 5'd24;   // block ending on a century year

    localparam logic [3:0] MON_JAN = 4'd1;
    localparam logic [3:0] MON_FEB = 4'd2;
    localparam logic [3:0] MON_DEC = 4'd12;

    localparam logic [4:0] MONTH_DAYS [13] = '{5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31,
                                               5'd30, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30,
                                               5'd31};

    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_DASH  = 7'h2D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;
    localparam logic [CHAR_W-1:0] CH_COLON = 7'h3A;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DAYS,
        S_ERA,
        S_CENT,
        S_QUAD,
        S_YEAR,
        S_MONTH,
        S_YSPLIT,
        S_HOUR,
        S_MIN,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [6:0] cent;
        logic [6:0] yy;
        logic [3:0] month;
        logic [4:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } t_fields;

    typedef struct packed {
        logic [3:0] tens;
        logic [3:0] ones;
    } t_digits;

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        len = (m > MON_DEC) ? 5'd0 : MONTH_DAYS[m];
        if (m == MON_FEB && leap) begin
            len = len + 5'd1;
        end
        return len;
    endfunction

    // 0..99 into two decimal digits; 205/2048 approximates 1/10 over this range
    function automatic t_digits split_tens(input logic [6:0] v);
        logic [14:0] prod;
        t_digits     d;
        prod   = 15'(v) * 15'd205;
        d.tens = prod[14:11];
        d.ones = 4'(v - 7'(d.tens) * 7'd10);
        return d;
    endfunction

endpackage

[hw/rtl/utdt_sub_unit.sv]
// Shared compare-and-subtract unit: one restoring-division step.
// Depends on utdt_pkg for the operand width.
module utdt_sub_unit
    import utdt_pkg::*;
(
    input  logic [REM_W-1:0] i_minuend,
    input  logic [REM_W-1:0] i_subtrahend,
    output logic             o_ge,
    output logic [REM_W-1:0] o_diff
);

    logic [REM_W:0] w_full;

    assign w_full = {1'b0, i_minuend} - {1'b0, i_subtrahend};
    assign o_ge   = ~w_full[REM_W];
    assign o_diff = w_full[REM_W-1:0];

endmodule

[hw/rtl/utdt_seq.sv]
// Sequencer and datapath registers: runs every division pass and the month
// search through the shared subtract unit. Depends on utdt_pkg, utdt_sub_unit.
module utdt_seq
    import utdt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [EPOCH_W-1:0] i_epoch_seconds,
    output logic               o_valid,
    input  logic               i_ready,
    output t_fields            o_fields,
    output logic [POS_W-1:0]   o_pos
);

    t_state             r_state, n_state;
    logic [POS_W-1:0]   r_pos;
    logic [REM_W-1:0]   r_rem;
    logic [QUO_W-1:0]   r_quo;
    logic [CNT_W-1:0]   r_cnt;
    logic [16:0]        r_sod;
    logic [YEAR_W-1:0]  r_year;
    logic [1:0]         r_q100;
    logic [4:0]         r_q4;
    logic               r_leap;
    t_fields            r_fields;

    logic [17:0]        w_divisor;
    logic [REM_W-1:0]   w_sub;
    logic               w_ge;
    logic [REM_W-1:0]   w_diff;
    logic [REM_W-1:0]   w_rem_step;
    logic [QUO_W-1:0]   w_quo_step;
    logic               w_last;
    logic               w_mon_more;
    logic [EPOCH_W-1:0] w_sat;
    logic               w_out_done;

    // divisor for the current pass
    always_comb begin
        unique case (r_state)
            S_DAYS:   w_divisor = 18'(DAY_SEC);
            S_ERA:    w_divisor = 18'(ERA_DAYS);
            S_CENT:   w_divisor = 18'(CENT_DAYS);
            S_QUAD:   w_divisor = 18'(QUAD_DAYS);
            S_YEAR:   w_divisor = 18'(YEAR_DAYS);
            S_YSPLIT: w_divisor = 18'(CENT_YEARS);
            S_HOUR:   w_divisor = 18'(HOUR_SEC);
            S_MIN:    w_divisor = 18'(MIN_SEC);
            default:  w_divisor = '0;
        endcase
    end

    assign w_sub = (r_state == S_MONTH) ? REM_W'(month_len(r_fields.month, r_leap))
                                        : (REM_W'(w_divisor) << r_cnt);

    utdt_sub_unit u_sub (
        .i_minuend    (r_rem),
        .i_subtrahend (w_sub),
        .o_ge         (w_ge),
        .o_diff       (w_diff)
    );

    assign w_rem_step = w_ge ? w_diff : r_rem;
    assign w_quo_step = {r_quo[QUO_W-2:0], w_ge};
    assign w_last     = (r_cnt == '0);
    assign w_mon_more = w_ge && (r_fields.month < MON_DEC);
    assign w_sat      = (i_epoch_seconds > MAX_EPOCH) ? MAX_EPOCH : i_epoch_seconds;
    assign w_out_done = i_ready && (r_pos == POS_W'(TEXT_LEN - 1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_valid) n_state = S_DAYS;
            S_DAYS:   if (w_last) n_state = S_ERA;
            S_ERA:    if (w_last) n_state = S_CENT;
            S_CENT:   if (w_last) n_state = S_QUAD;
            S_QUAD:   if (w_last) n_state = S_YEAR;
            S_YEAR:   if (w_last) n_state = S_MONTH;
            S_MONTH:  if (!w_mon_more) n_state = S_YSPLIT;
            S_YSPLIT: if (w_last) n_state = S_HOUR;
            S_HOUR:   if (w_last) n_state = S_MIN;
            S_MIN:    if (w_last) n_state = S_EMIT;
            S_EMIT:   if (w_out_done) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        o_ready = (r_state == S_IDLE);
        o_valid = (r_state == S_EMIT);
    end

    assign o_fields = r_fields;
    assign o_pos    = r_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pos   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_EMIT && i_ready) begin
                r_pos <= w_out_done ? '0 : r_pos + 1'b1;
            end
        end
    end

    // datapath: one division step per cycle, pass results captured on the last step
    always_ff @(posedge i_clk) begin
        r_rem <= w_rem_step;
        r_quo <= w_quo_step;
        r_cnt <= r_cnt - 1'b1;
        unique case (r_state)
            S_IDLE: begin
                r_rem <= w_sat;
                r_quo <= '0;
                r_cnt <= CNT_DAYS;
            end
            S_DAYS: if (w_last) begin
                r_sod <= 17'(w_rem_step);
                r_rem <= REM_W'(w_quo_step) + REM_W'(BASE_OFFSET);
                r_quo <= '0;
                r_cnt <= CNT_ERA;
            end
            S_ERA: if (w_last) begin
                r_year <= YEAR_W'(BASE_YEAR) + YEAR_W'(w_quo_step[4:0]) * YEAR_W'(400);
                r_quo  <= '0;
                r_cnt  <= CNT_CENT;
            end
            S_CENT: if (w_last) begin
                r_q100 <= w_quo_step[1:0];
                r_year <= r_year + YEAR_W'(w_quo_step[1:0]) * YEAR_W'(100);
                r_quo  <= '0;
                r_cnt  <= CNT_QUAD;
            end
            S_QUAD: if (w_last) begin
                r_q4   <= w_quo_step[4:0];
                r_year <= r_year + YEAR_W'({w_quo_step[4:0], 2'b00});
                r_quo  <= '0;
                r_cnt  <= CNT_YEAR;
            end
            S_YEAR: if (w_last) begin
                r_year         <= r_year + YEAR_W'(w_quo_step[1:0]);
                r_leap         <= (w_quo_step[1:0] == Q1_LAST)
                                  && ((r_q4 != Q4_LAST) || (r_q100 == Q100_LAST));
                r_fields.month <= MON_JAN;
            end
            S_MONTH: begin
                if (w_mon_more) begin
                    r_rem          <= w_diff;
                    r_fields.month <= r_fields.month + 4'd1;
                end else begin
                    r_fields.day <= 5'(r_rem) + 5'd1;
                    r_rem        <= REM_W'(r_year);
                    r_quo        <= '0;
                    r_cnt        <= CNT_YSPL;
                end
            end
            S_YSPLIT: if (w_last) begin
                r_fields.cent <= 7'(w_quo_step);
                r_fields.yy   <= 7'(w_rem_step);
                r_rem         <= REM_W'(r_sod);
                r_quo         <= '0;
                r_cnt         <= CNT_HOUR;
            end
            S_HOUR: if (w_last) begin
                r_fields.hour <= 5'(w_quo_step);
                r_quo         <= '0;
                r_cnt         <= CNT_MIN;
            end
            S_MIN: if (w_last) begin
                r_fields.minute <= 6'(w_quo_step);
                r_fields.second <= 6'(w_rem_step);
            end
            default: ;
        endcase
    end

endmodule

[hw/rtl/utdt_text.sv]
// Character formatter: picks the ASCII character for one text position.
// Depends on utdt_pkg for field layout, digit split and character codes.
module utdt_text
    import utdt_pkg::*;
(
    input  t_fields           i_fields,
    input  logic [POS_W-1:0]  i_pos,
    output logic [CHAR_W-1:0] o_char,
    output logic              o_last
);

    t_digits w_cent, w_yy, w_mon, w_day, w_hour, w_min, w_sec;
    logic [3:0] w_digit;
    logic       w_is_digit;
    logic [CHAR_W-1:0] w_sep;

    assign w_cent = split_tens(i_fields.cent);
    assign w_yy   = split_tens(i_fields.yy);
    assign w_mon  = split_tens(7'(i_fields.month));
    assign w_day  = split_tens(7'(i_fields.day));
    assign w_hour = split_tens(7'(i_fields.hour));
    assign w_min  = split_tens(7'(i_fields.minute));
    assign w_sec  = split_tens(7'(i_fields.second));

    always_comb begin
        w_digit    = '0;
        w_is_digit = 1'b1;
        w_sep      = CH_DASH;
        unique case (i_pos)
            5'd0:  w_digit = w_cent.tens;
            5'd1:  w_digit = w_cent.ones;
            5'd2:  w_digit = w_yy.tens;
            5'd3:  w_digit = w_yy.ones;
            5'd5:  w_digit = w_mon.tens;
            5'd6:  w_digit = w_mon.ones;
            5'd8:  w_digit = w_day.tens;
            5'd9:  w_digit = w_day.ones;
            5'd11: w_digit = w_hour.tens;
            5'd12: w_digit = w_hour.ones;
            5'd14: w_digit = w_min.tens;
            5'd15: w_digit = w_min.ones;
            5'd17: w_digit = w_sec.tens;
            5'd18: w_digit = w_sec.ones;
            5'd10: begin
                w_is_digit = 1'b0;
                w_sep      = CH_SPACE;
            end
            5'd13, 5'd16: begin
                w_is_digit = 1'b0;
                w_sep      = CH_COLON;
            end
            default: w_is_digit = 1'b0;   // date dashes
        endcase
    end

    assign o_char = w_is_digit ? (CH_ZERO + CHAR_W'(w_digit)) : w_sep;
    assign o_last = (i_pos == POS_W'(TEXT_LEN - 1));

endmodule

[hw/rtl/unix_time_to_date_text_unit.sv]
// Top level of the epoch-to-date text unit.
// Depends on utdt_pkg, utdt_seq (with utdt_sub_unit) and utdt_text.
//
// Usage:
//   Input channel (i_valid / o_ready): one word is a 38-bit count of seconds since
//   1970-01-01 00:00:00 UTC. Counts past 9999-12-31 23:59:59 clamp to that instant.
//   Output channel (o_valid / i_ready): 19 words per input, the text
//   "YYYY-MM-DD HH:MM:SS" in order, one ASCII character per word with its
//   position 0..18; o_last_char marks the seconds units digit.
// Operation: every division is a restoring pass through one shared 38-bit
//   compare/subtract unit, one quotient bit per cycle, in the order days,
//   era, century, 4-year and year; the month search then runs through the
//   same unit, followed by the year split, hour and minute passes.
// Flow: o_ready is high only while idle, so one word is in flight at a time.
// Stall: characters are held from registers; o_valid and the current
//   character stay put until i_ready, nothing is dropped or repeated.
// Reset: synchronous active-low i_rst_n returns the sequencer to idle and
//   drops any partly sent text. No clearing pass is needed.
module unix_time_to_date_text_unit
    import utdt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [EPOCH_W-1:0] i_epoch_seconds,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [CHAR_W-1:0]  o_text_char,
    output logic [POS_W-1:0]   o_char_position,
    output logic               o_last_char
);

    t_fields          w_fields;   // decoded date/time fields, held during output
    logic [POS_W-1:0] w_pos;      // position of the character on offer

    // sequencer: divisions, year/month search, output position counter
    utdt_seq u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_epoch_seconds (i_epoch_seconds),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_fields        (w_fields),
        .o_pos           (w_pos)
    );

    // per-position character selection
    utdt_text u_text (
        .i_fields (w_fields),
        .i_pos    (w_pos),
        .o_char   (o_text_char),
        .o_last   (o_last_char)
    );

    assign o_char_position = w_pos;

endmodule

[hw/rtl/utdt_checker.sv]
// Port-level checks for unix_time_to_date_text_unit, bound to the top level.
// Depends on utdt_pkg for widths and character codes.
module utdt_checker
    import utdt_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input logic [CHAR_W-1:0]  o_text_char,
    input logic [POS_W-1:0]   o_char_position,
    input logic               o_last_char
);

    // stalled output word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_text_char) && $stable(o_char_position))
        else $error("output word changed while stalled");

    // one word at a time: never taking input while text is going out
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("input ready while text is pending");

    // characters come out in text order without gaps
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last_char |=>
            o_valid && (o_char_position == $past(o_char_position) + 5'd1))
        else $error("character position skipped or repeated");

    // last flag sits on the final position only
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_char == (o_char_position == POS_W'(TEXT_LEN - 1))))
        else $error("last flag misplaced");

    // fixed separators of the date text
    a_sep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_char_position == 5'd4 || o_char_position == 5'd7)
            |-> o_text_char == CH_DASH)
        else $error("date separator wrong");

endmodule

bind unix_time_to_date_text_unit utdt_checker u_chk (.*);
